>>> rtl/core/periodic_task_tick_table_core_defines.svh
// ----------------------------------------------------------------------------
// Periodic task tick table - assertion macros
// Shared assertion shorthands for the checker of the tick table core.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_TICK_TABLE_CORE_DEFINES_SVH

// Concurrent assertion on a given clock, disabled while reset is asserted.
`define PTT_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PTT_ASSERT(label, prop, msg) \
    `PTT_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick table - package
// Operation and status codes and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int PERIOD_IN_W = 16;
    localparam int MASK_W      = 8;
    localparam int SLOT_ID_W   = 3;
    localparam int STATUS_W    = 2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_CREATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_TICK      = 2'd0,
        ST_CREATED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_INIT_FAIL = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/periodic_task_tick_table_core.sv
// ----------------------------------------------------------------------------
// Periodic task tick table - core
// Table of periodic task slots: creates tasks and reports which fire per tick.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ channel (valid/ready) and results leave on the m_
// channel (valid/ready), one result for every item. A tick item advances the
// counter of every occupied slot and returns a fire mask; a create item claims
// the lowest free slot and returns its number with a status code.
// An item is captured in the input register, then the slot table is updated
// and the result register loaded from it. Throughput is one item per cycle
// while the receiver does not stall, set by the single pass over all slots
// between the input and result registers.
// A stalled receiver holds the result register; the input register keeps
// filling while the result waits, and s_ready drops only once both hold an
// item. Reset empties the table and both registers; periods and counters are
// left as they are and are only read once a create has written them.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_table_core #(
    parameter int SLOTS       = 8,
    parameter int PERIOD_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_opcode,
    input  wire logic [ptt_pkg::PERIOD_IN_W-1:0]      s_period,
    input  wire logic                                 s_has_init,
    input  wire logic                                 s_init_ok,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [ptt_pkg::MASK_W-1:0]                m_fire_mask,
    output logic [ptt_pkg::SLOT_ID_W-1:0]             m_slot_id,
    output logic [ptt_pkg::STATUS_W-1:0]              m_status
);

    import ptt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Input register.
    logic                   in_valid_reg, in_valid_next;
    logic                   op_reg;
    logic [PERIOD_IN_W-1:0] period_reg;
    logic                   has_init_reg;
    logic                   init_ok_reg;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]      fire_mask_reg, fire_mask_next;
    logic [SLOT_ID_W-1:0]   slot_id_reg, slot_id_next;
    status_t                status_reg, status_next;

    // Slot table.
    logic [SLOTS-1:0]       slot_valid_reg, slot_valid_next;
    logic [PERIOD_BITS-1:0] slot_period_reg [SLOTS];
    logic [PERIOD_BITS-1:0] slot_count_reg  [SLOTS];
    logic [PERIOD_BITS-1:0] slot_count_next [SLOTS];

    logic                   advance;
    logic                   s_accept;
    logic                   is_create;
    logic                   any_free;
    logic [SLOT_W-1:0]      free_idx;
    logic [SLOTS-1:0]       fired;
    logic [PERIOD_BITS-1:0] period_in;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign is_create = (op_reg == OP_CREATE);
    assign period_in = PERIOD_BITS'(period_reg);

    // Lowest free slot.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Per-slot counter update on a tick.
    always_comb begin
        logic [PERIOD_BITS-1:0] cnt_inc;
        for (int i = 0; i < SLOTS; i++) begin
            cnt_inc            = slot_count_reg[i] + 1'b1;
            fired[i]           = slot_valid_reg[i] && (cnt_inc >= slot_period_reg[i]);
            slot_count_next[i] = fired[i] ? '0 : cnt_inc;
        end
    end

    always_comb begin
        slot_valid_next = slot_valid_reg;
        fire_mask_next  = '0;
        slot_id_next    = '0;
        status_next     = ST_TICK;
        if (is_create) begin
            if (any_free) begin
                slot_valid_next[free_idx] = 1'b1;
                slot_id_next = SLOT_ID_W'(free_idx);
                status_next  = (has_init_reg && !init_ok_reg) ? ST_INIT_FAIL : ST_CREATED;
            end else begin
                status_next = ST_FULL;
            end
        end else begin
            fire_mask_next = MASK_W'(fired);
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                slot_valid_reg <= slot_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_opcode;
            period_reg   <= s_period;
            has_init_reg <= s_has_init;
            init_ok_reg  <= s_init_ok;
        end
        if (advance) begin
            fire_mask_reg <= fire_mask_next;
            slot_id_reg   <= slot_id_next;
            status_reg    <= status_next;
        end
    end

    // Slot storage: a create into a free slot writes one entry, a tick updates the counter of every occupied slot.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (is_create) begin
                if (any_free) begin
                    slot_period_reg[free_idx] <= period_in;
                    slot_count_reg[free_idx]  <= '0;
                end
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid_reg[i]) begin
                        slot_count_reg[i] <= slot_count_next[i];
                    end
                end
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_fire_mask = fire_mask_reg;
    assign m_slot_id   = slot_id_reg;
    assign m_status    = status_reg;

endmodule

`default_nettype wire

>>> rtl/core/ptt_checker.sv
// ----------------------------------------------------------------------------
// Periodic task tick table - port checker
// Watches the ports of the core and checks the shape of every result item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_tick_table_core_defines.svh"

module ptt_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [ptt_pkg::MASK_W-1:0]       m_fire_mask,
    input wire logic [ptt_pkg::SLOT_ID_W-1:0]    m_slot_id,
    input wire logic [ptt_pkg::STATUS_W-1:0]     m_status
);

    import ptt_pkg::*;

    // A stalled result item keeps its valid and its payload.
    `PTT_ASSERT(a_result_held, (m_valid && !m_ready) |=> (m_valid && $stable(m_fire_mask) && $stable(m_slot_id) && $stable(m_status)), "result item changed while stalled")

    // Only a tick item can report fired slots.
    `PTT_ASSERT(a_create_no_fire, (m_valid && (m_status != ST_TICK)) |-> (m_fire_mask == '0), "fire mask set on a create result")

    // A tick item reports no slot.
    `PTT_ASSERT(a_tick_no_slot, (m_valid && (m_status == ST_TICK)) |-> (m_slot_id == '0), "slot id set on a tick result")

    // A full table reports no slot.
    `PTT_ASSERT(a_full_no_slot, (m_valid && (m_status == ST_FULL)) |-> (m_slot_id == '0), "slot id set on a table full result")

endmodule

bind periodic_task_tick_table_core ptt_checker u_ptt_checker (.*);

`default_nettype wire

>>> verif/ptt_tb_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick table - scoreboard package
// Holds a cycle-free model of the slot table and the queue of expected results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package ptt_tb_pkg;

    import ptt_pkg::*;

    localparam int TABLE_SLOTS = 8;
    localparam int COUNT_W     = 16;

    typedef struct packed {
        logic [MASK_W-1:0]    fire_mask;
        logic [SLOT_ID_W-1:0] slot_id;
        status_t              status;
    } tick_result_t;

    class tick_table_scoreboard;

        bit                 slot_used   [TABLE_SLOTS];
        logic [COUNT_W-1:0] slot_period [TABLE_SLOTS];
        logic [COUNT_W-1:0] slot_count  [TABLE_SLOTS];
        tick_result_t       expected_results [$];

        int unsigned mismatches;
        int unsigned ticks_seen;
        int unsigned creates_seen;
        int unsigned fires_seen;
        int unsigned full_seen;
        int unsigned init_fails_seen;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i]   = 1'b0;
                slot_period[i] = '0;
                slot_count[i]  = '0;
            end
            mismatches      = 0;
            ticks_seen      = 0;
            creates_seen    = 0;
            fires_seen      = 0;
            full_seen       = 0;
            init_fails_seen = 0;
        endfunction

        // Every occupied slot counts in parallel; a slot that reaches its
        // period fires and starts again from zero.
        function logic [MASK_W-1:0] advance_counters();
            logic [MASK_W-1:0]  fired;
            logic [COUNT_W-1:0] next_count;
            fired = '0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i]) begin
                    next_count = slot_count[i] + 1'b1;
                    if (next_count >= slot_period[i]) begin
                        fired[i]      = 1'b1;
                        slot_count[i] = '0;
                    end else begin
                        slot_count[i] = next_count;
                    end
                end
            end
            return fired;
        endfunction

        // A failed init hook still leaves the slot occupied.
        function tick_result_t claim_slot(logic [COUNT_W-1:0] period, logic has_init,
                                          logic init_ok);
            tick_result_t res;
            bit           found;
            res   = '{fire_mask: '0, slot_id: '0, status: ST_FULL};
            found = 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (!found && !slot_used[i]) begin
                    found          = 1'b1;
                    slot_used[i]   = 1'b1;
                    slot_period[i] = period;
                    slot_count[i]  = '0;
                    res.slot_id    = SLOT_ID_W'(i);
                    res.status     = (has_init && !init_ok) ? ST_INIT_FAIL : ST_CREATED;
                end
            end
            return res;
        endfunction

        function void note_accepted_item(logic opcode, logic [PERIOD_IN_W-1:0] period,
                                         logic has_init, logic init_ok);
            tick_result_t res;
            if (opcode == OP_TICK) begin
                res = '{fire_mask: advance_counters(), slot_id: '0, status: ST_TICK};
                ticks_seen++;
                fires_seen += $countones(res.fire_mask);
            end else begin
                res = claim_slot(period, has_init, init_ok);
                creates_seen++;
                if (res.status == ST_FULL)
                    full_seen++;
                if (res.status == ST_INIT_FAIL)
                    init_fails_seen++;
            end
            expected_results.push_back(res);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [MASK_W-1:0] fire_mask, logic [SLOT_ID_W-1:0] slot_id,
                          logic [STATUS_W-1:0] status);
            tick_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (mask %02h slot %0d st %0d)",
                                          fire_mask, slot_id, status));
            end else begin
                want = expected_results.pop_front();
                if (fire_mask !== want.fire_mask)
                    report_mismatch($sformatf("fire_mask %02h, expected %02h",
                                              fire_mask, want.fire_mask));
                if (slot_id !== want.slot_id)
                    report_mismatch($sformatf("slot_id %0d, expected %0d",
                                              slot_id, want.slot_id));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              status, want.status.name()));
            end
        endtask

    endclass

endpackage

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Periodic task tick table - testbench
// Fills the slot table with a spread of periods and init outcomes, then runs
// random ticks and surplus creates under varied idling and back-pressure,
// checking every result against the scoreboard's own table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import ptt_pkg::*;
    import ptt_tb_pkg::*;

    localparam int ITEMS_PER_PHASE  = 250;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT      = 200000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic                   s_opcode   = OP_TICK;
    logic [PERIOD_IN_W-1:0] s_period   = '0;
    logic                   s_has_init = 1'b0;
    logic                   s_init_ok  = 1'b0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [MASK_W-1:0]      m_fire_mask;
    logic [SLOT_ID_W-1:0]   m_slot_id;
    logic [STATUS_W-1:0]    m_status;

    tick_table_scoreboard sb;

    int unsigned cycle_count   = 0;
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    bit          long_hold_req = 1'b0;

    periodic_task_tick_table_core #(
        .SLOTS       (TABLE_SLOTS),
        .PERIOD_BITS (COUNT_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_period    (s_period),
        .s_has_init  (s_has_init),
        .s_init_ok   (s_init_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fire_mask (m_fire_mask),
        .m_slot_id   (m_slot_id),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_fire_mask, m_slot_id, m_status);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(logic opcode, logic [PERIOD_IN_W-1:0] period,
                             logic has_init, logic init_ok);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= opcode;
        s_period   <= period;
        s_has_init <= has_init;
        s_init_ok  <= init_ok;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_accepted_item(opcode, period, has_init, init_ok);
    endtask

    task automatic send_random_item();
        logic opcode;
        opcode = ($urandom_range(0, 99) < 15) ? OP_CREATE : OP_TICK;
        send_item(opcode, PERIOD_IN_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the table: zero period, largest period, no hook with init_ok
        // set, failing hooks, passing hooks, then two creates on a full table.
        send_item(OP_CREATE, 16'd0, 1'b0, 1'b0);
        send_item(OP_TICK, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_CREATE, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_CREATE, 16'd2, 1'b1, 1'b0);
        send_item(OP_CREATE, 16'd1, 1'b0, 1'b1);
        send_item(OP_TICK, 16'd0, 1'b0, 1'b0);
        send_item(OP_CREATE, 16'd3, 1'b1, 1'b0);
        send_item(OP_CREATE, PERIOD_IN_W'($urandom_range(4, 12)), 1'b0, 1'b0);
        send_item(OP_CREATE, PERIOD_IN_W'($urandom_range(5, 20)), 1'b1, 1'b1);
        send_item(OP_CREATE, PERIOD_IN_W'($urandom_range(1, 40)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(OP_CREATE, 16'd100, 1'b1, 1'b0);
        send_item(OP_CREATE, 16'hFFFF, 1'b0, 1'b0);
        repeat (10) send_item(OP_TICK, 16'hA5A5, 1'b1, 1'b0);
        wait_until_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // The sender keeps offering through the hold-off, so both
                // internal registers fill and the input stalls.
                if (phase == 0 && k == 100)
                    long_hold_req = 1'b1;
                if (phase == 2 && k == 125)
                    wait_until_drained();
                send_random_item();
            end
            wait_until_drained();
        end

        repeat (10) @(posedge aclk);

        $display("Covered %0d ticks and %0d creates (%0d on a full table, %0d failed inits)",
                 sb.ticks_seen, sb.creates_seen, sb.full_seen, sb.init_fails_seen);
        $display("Saw %0d slot firings across %0d cycles, %0d mismatches",
                 sb.fires_seen, cycle_count, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ptt_pkg.sv
rtl/core/periodic_task_tick_table_core.sv
rtl/core/ptt_checker.sv
verif/ptt_tb_pkg.sv
verif/tb.sv
